/* rtl/core/iirdf1_pkg.sv */
package iirdf1_pkg;

   // Filter size and coefficient format.
   localparam int TAPS           = 9;
   localparam int COEF_FRAC_BITS = 24;
   localparam int HIST           = TAPS - 1;
   localparam int TABLE_LEN      = 16;

   // Field and word widths.
   localparam int SAMPLE_W   = 16;
   localparam int HIST_W     = 32;
   localparam int COEF_W     = 32;
   localparam int OUT_FRAC   = HIST_W - SAMPLE_W;

   // Digit-serial multiplier: one digit of the data operand per cycle.
   localparam int DIGIT_W    = 8;
   localparam int FF_DIGITS  = SAMPLE_W / DIGIT_W;
   localparam int FB_DIGITS  = HIST_W / DIGIT_W;
   localparam int DIG_CNT_W  = $clog2(FB_DIGITS);
   localparam int PART_W     = COEF_W + DIGIT_W + 1;
   localparam int PROD_W     = COEF_W + HIST_W;

   // Term sequencing: TAPS feed-forward terms followed by HIST feedback terms.
   localparam int NTERM      = 2 * TAPS - 1;
   localparam int TERM_W     = $clog2(NTERM);
   localparam int HIDX_W     = (HIST > 1) ? $clog2(HIST) : 1;
   localparam int COEF_IDX_W = $clog2(TABLE_LEN);

   // Every aligned product stays below 2**(62-COEF_FRAC_BITS) in magnitude,
   // and at most 31 of them are summed.
   localparam int ACC_W      = 68 - COEF_FRAC_BITS;

   // Shift that brings a feed-forward product to 16 fraction bits.
   localparam int FF_SHR     = (COEF_FRAC_BITS >= OUT_FRAC) ? COEF_FRAC_BITS - OUT_FRAC : 0;
   localparam int FF_SHL     = (COEF_FRAC_BITS < OUT_FRAC) ? OUT_FRAC - COEF_FRAC_BITS : 0;

   // Round a decimal coefficient mag / 10**dexp to fixed point, ties away from
   // zero, and saturate it to the signed coefficient range.
   function automatic logic signed [COEF_W-1:0] coef_fixed(
      input logic [29:0] mag,
      input logic        neg,
      input logic [3:0]  dexp
   );
      logic [63:0] num;
      logic [63:0] q;
      num = {34'd0, mag} << COEF_FRAC_BITS;
      case (dexp)
         4'd7:    q = (num + 64'd5000000) / 64'd10000000;
         4'd8:    q = (num + 64'd50000000) / 64'd100000000;
         4'd9:    q = (num + 64'd500000000) / 64'd1000000000;
         4'd10:   q = (num + 64'd5000000000) / 64'd10000000000;
         default: q = num;
      endcase
      if (neg) begin
         if (q > 64'h8000_0000) q = 64'h8000_0000;
         coef_fixed = ~q[COEF_W-1:0] + COEF_W'(1);
      end else begin
         if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
         coef_fixed = q[COEF_W-1:0];
      end
   endfunction

   // Feed-forward coefficients b[0..15]; entries past the ninth are zero.
   localparam logic signed [COEF_W-1:0] FF_COEF [TABLE_LEN] = '{
      coef_fixed(30'd985496564, 1'b0, 4'd10),
      coef_fixed(30'd772311598, 1'b1, 4'd9),
      coef_fixed(30'd266384542, 1'b0, 4'd8),
      coef_fixed(30'd528134630, 1'b1, 4'd8),
      coef_fixed(30'd658252588, 1'b0, 4'd8),
      coef_fixed(30'd528134630, 1'b1, 4'd8),
      coef_fixed(30'd266384542, 1'b0, 4'd8),
      coef_fixed(30'd772311598, 1'b1, 4'd9),
      coef_fixed(30'd985496564, 1'b0, 4'd10),
      {COEF_W{1'b0}}, {COEF_W{1'b0}}, {COEF_W{1'b0}}, {COEF_W{1'b0}},
      {COEF_W{1'b0}}, {COEF_W{1'b0}}, {COEF_W{1'b0}}
   };

   // Feedback coefficients a[0..15]; a[0] is implied and never used.
   localparam logic signed [COEF_W-1:0] FB_COEF [TABLE_LEN] = '{
      {COEF_W{1'b0}},
      coef_fixed(30'd780973974, 1'b1, 4'd8),
      coef_fixed(30'd268412482, 1'b0, 4'd7),
      coef_fixed(30'd530198282, 1'b1, 4'd7),
      coef_fixed(30'd658319005, 1'b0, 4'd7),
      coef_fixed(30'd526124756, 1'b1, 4'd7),
      coef_fixed(30'd264303907, 1'b0, 4'd7),
      coef_fixed(30'd763111434, 1'b1, 4'd8),
      coef_fixed(30'd969621051, 1'b0, 4'd9),
      {COEF_W{1'b0}}, {COEF_W{1'b0}}, {COEF_W{1'b0}}, {COEF_W{1'b0}},
      {COEF_W{1'b0}}, {COEF_W{1'b0}}, {COEF_W{1'b0}}
   };

   // Per-digit control that travels with each multiplier operand.
   typedef struct packed {
      logic vld;
      logic first;
      logic last;
      logic fb;
      logic item_first;
      logic item_last;
   } mac_flags_type;

   // One digit step: coefficient, signed data digit and control.
   typedef struct packed {
      mac_flags_type              flags;
      logic signed [COEF_W-1:0]   coef;
      logic signed [DIGIT_W:0]    digit;
   } mac_op_type;

   // A finished Q15.16 filter output.
   typedef struct packed {
      logic                     vld;
      logic signed [HIST_W-1:0] y;
   } mac_res_type;

endpackage

/* rtl/core/iirdf1_req_if.sv */
interface iirdf1_req_if;
   import iirdf1_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] in_sample;

   modport source (output valid, output in_sample, input ready);
   modport sink (input valid, input in_sample, output ready);

endinterface

/* rtl/core/iirdf1_rsp_if.sv */
interface iirdf1_rsp_if;
   import iirdf1_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] out_sample;

   modport source (output valid, output out_sample, input ready);
   modport sink (input valid, input out_sample, output ready);

endinterface

/* rtl/core/iirdf1_mac.sv */
module iirdf1_mac (
   input  logic                     clock,
   input  logic                     reset,
   input  iirdf1_pkg::mac_op_type   op,
   output iirdf1_pkg::mac_res_type  res
);
   import iirdf1_pkg::*;

   localparam logic signed [ACC_W-1:0] Y_MAX =
      {{(ACC_W - HIST_W + 1){1'b0}}, {(HIST_W - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] Y_MIN =
      {{(ACC_W - HIST_W + 1){1'b1}}, {(HIST_W - 1){1'b0}}};

   logic signed [PART_W-1:0] part_in, part_ff;
   mac_flags_type            fl1_ff, fl2_ff;
   logic signed [PROD_W-1:0] part_ext;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic signed [PROD_W-1:0] aligned;
   logic signed [ACC_W-1:0]  term_val;
   logic signed [ACC_W-1:0]  acc_base;
   logic signed [ACC_W-1:0]  acc_in, acc_ff;
   logic                     done3_ff;
   logic signed [HIST_W-1:0] y_in, y_ff;
   logic                     done4_ff;

   // Stage 1: coefficient times one signed data digit.
   assign part_in = PART_W'(op.coef) * PART_W'(op.digit);

   // Stage 2: most significant digit first, so the running product moves
   // up one digit before each new partial product is added.
   assign part_ext = PROD_W'(part_ff);
   assign prod_in  = fl1_ff.first ? part_ext : (prod_ff <<< DIGIT_W) + part_ext;

   // Stage 3: bring the finished product to 16 fraction bits (floor) and
   // add it to the sum, or subtract it for a feedback term.
   always_comb begin
      if (fl2_ff.fb) begin
         aligned = prod_ff >>> COEF_FRAC_BITS;
      end else begin
         aligned = (prod_ff >>> FF_SHR) <<< FF_SHL;
      end
      term_val = ACC_W'(aligned);
      acc_base = fl2_ff.item_first ? {ACC_W{1'b0}} : acc_ff;
      acc_in   = fl2_ff.fb ? acc_base - term_val : acc_base + term_val;
   end

   // Stage 4: saturate the sum to the 32-bit output history format.
   always_comb begin
      if (acc_ff > Y_MAX) begin
         y_in = Y_MAX[HIST_W-1:0];
      end else if (acc_ff < Y_MIN) begin
         y_in = Y_MIN[HIST_W-1:0];
      end else begin
         y_in = acc_ff[HIST_W-1:0];
      end
   end

   // Pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         fl1_ff   <= '0;
         fl2_ff   <= '0;
         done3_ff <= 1'b0;
         done4_ff <= 1'b0;
      end else begin
         fl1_ff   <= op.flags;
         fl2_ff   <= fl1_ff;
         done3_ff <= fl2_ff.vld && fl2_ff.last && fl2_ff.item_last;
         done4_ff <= done3_ff;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      part_ff <= part_in;
      if (fl1_ff.vld) prod_ff <= prod_in;
      if (fl2_ff.vld && fl2_ff.last) acc_ff <= acc_in;
      if (done3_ff) y_ff <= y_in;
   end

   assign res.vld = done4_ff;
   assign res.y   = y_ff;

endmodule

/* rtl/core/iirdf1_seq.sv */
module iirdf1_seq (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] req_sample,
   output iirdf1_pkg::mac_op_type                 op,
   input  iirdf1_pkg::mac_res_type                res,
   output iirdf1_pkg::mac_res_type                hold,
   input  logic                                   take
);
   import iirdf1_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_HOLD
   } state_type;

   state_type                  state_ff, state_in;
   logic [TERM_W-1:0]          term_ff, term_in;
   logic [DIG_CNT_W-1:0]       dig_ff, dig_in;
   logic                       first_ff, first_in;
   logic [HIST_W-1:0]          opnd_ff, opnd_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [SAMPLE_W-1:0] x_hist_ff [HIST];
   logic signed [SAMPLE_W-1:0] x_hist_in [HIST];
   logic signed [HIST_W-1:0]   y_hist_ff [HIST];
   logic signed [HIST_W-1:0]   y_hist_in [HIST];
   logic signed [HIST_W-1:0]   y_hold_ff, y_hold_in;

   logic                       term_fb;
   logic                       term_last;
   logic [COEF_IDX_W-1:0]      coef_idx;
   logic                       next_fb;
   logic [HIDX_W-1:0]          x_idx;
   logic [HIDX_W-1:0]          y_idx;
   logic [HIST_W-1:0]          next_opnd;

   // Which coefficient and history entry belong to the current term.
   always_comb begin
      term_fb   = term_ff > TERM_W'(HIST);
      term_last = term_ff == TERM_W'(NTERM - 1);
      coef_idx  = term_fb ? COEF_IDX_W'(term_ff - TERM_W'(HIST)) : COEF_IDX_W'(term_ff);
      next_fb   = term_ff >= TERM_W'(HIST);
      x_idx     = HIDX_W'(term_ff);
      y_idx     = HIDX_W'(term_ff - TERM_W'(HIST));
      next_opnd = next_fb ? y_hist_ff[y_idx]
                          : {x_hist_ff[x_idx], {(HIST_W - SAMPLE_W){1'b0}}};
   end

   // Digit stream to the multiplier: the top digit of the operand shift
   // register, signed on the first digit of a term.
   always_comb begin
      op.flags.vld        = state_ff == ST_ISSUE;
      op.flags.first      = first_ff;
      op.flags.last       = dig_ff == '0;
      op.flags.fb         = term_fb;
      op.flags.item_first = term_ff == '0;
      op.flags.item_last  = term_last;
      op.coef             = term_fb ? FB_COEF[coef_idx] : FF_COEF[coef_idx];
      op.digit            = {first_ff & opnd_ff[HIST_W-1], opnd_ff[HIST_W-1 -: DIGIT_W]};
   end

   assign req_ready = state_ff == ST_IDLE;
   assign hold.vld  = state_ff == ST_HOLD;
   assign hold.y    = y_hold_ff;

   // Sequencer next state.
   always_comb begin
      state_in  = state_ff;
      term_in   = term_ff;
      dig_in    = dig_ff;
      first_in  = first_ff;
      opnd_in   = opnd_ff;
      x_in      = x_ff;
      x_hist_in = x_hist_ff;
      y_hist_in = y_hist_ff;
      y_hold_in = y_hold_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in     = req_sample;
               term_in  = '0;
               dig_in   = DIG_CNT_W'(FF_DIGITS - 1);
               first_in = 1'b1;
               opnd_in  = {req_sample, {(HIST_W - SAMPLE_W){1'b0}}};
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (dig_ff != '0) begin
               dig_in   = dig_ff - DIG_CNT_W'(1);
               opnd_in  = opnd_ff << DIGIT_W;
               first_in = 1'b0;
            end else if (term_last) begin
               state_in = ST_DRAIN;
            end else begin
               term_in  = term_ff + TERM_W'(1);
               first_in = 1'b1;
               opnd_in  = next_opnd;
               dig_in   = next_fb ? DIG_CNT_W'(FB_DIGITS - 1) : DIG_CNT_W'(FF_DIGITS - 1);
            end
         end
         ST_DRAIN: begin
            // The output is final: age both histories by one sample.
            if (res.vld) begin
               y_hold_in    = res.y;
               x_hist_in[0] = x_ff;
               y_hist_in[0] = res.y;
               for (int i = 1; i < HIST; i++) begin
                  x_hist_in[i] = x_hist_ff[i-1];
                  y_hist_in[i] = y_hist_ff[i-1];
               end
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (take) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, histories and sequencing registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < HIST; i++) begin
            x_hist_ff[i] <= '0;
            y_hist_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         term_ff   <= term_in;
         dig_ff    <= dig_in;
         first_ff  <= first_in;
         opnd_ff   <= opnd_in;
         x_ff      <= x_in;
         x_hist_ff <= x_hist_in;
         y_hist_ff <= y_hist_in;
         y_hold_ff <= y_hold_in;
      end
   end

endmodule

/* rtl/core/iir_direct_form1_order8_top.sv */
// Eighth-order direct-form-I IIR filter, one signed 16-bit sample in and one
// rounded, saturated 16-bit sample out per transaction.
// Channels: req_chan carries in_sample, rsp_chan carries out_sample; each
// transaction completes on a clock edge where valid and ready are both high.
// Every input transaction yields exactly one output transaction, in order.
// Work per sample: one shared 32 x 9 multiplier takes one 8-bit digit of the
// data operand per cycle, two digits for each of the TAPS input terms and four
// for each of the TAPS-1 output-history terms, followed by a four-stage
// product, align, accumulate and saturate pipeline.
// One sample is in work at a time: req_chan.ready is high only while no
// sample is in work.
// Reset (synchronous, active high) clears both histories to zero and empties
// the block; req_chan.ready is high on the first cycle after it.
// If the receiver stalls, the result waits in the output register and one
// more finished sample can wait inside; further inputs then wait.
module iir_direct_form1_order8_top (
   input  logic                clock,
   input  logic                reset,
   iirdf1_req_if.sink          req_chan,
   iirdf1_rsp_if.source        rsp_chan
);
   import iirdf1_pkg::*;

   mac_op_type                 op;
   mac_res_type                res;
   mac_res_type                hold;
   logic                       take;
   logic signed [HIST_W:0]     rnd_sum;
   logic signed [SAMPLE_W:0]   rnd_hi;
   logic signed [SAMPLE_W-1:0] sat_sample;
   logic                       out_vld_ff;
   logic signed [SAMPLE_W-1:0] out_sample_ff;

   iirdf1_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_sample (req_chan.in_sample),
      .op         (op),
      .res        (res),
      .hold       (hold),
      .take       (take)
   );

   iirdf1_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .res   (res)
   );

   // Round Q15.16 to an integer (add one half, floor) and saturate to 16 bits.
   always_comb begin
      rnd_sum = {hold.y[HIST_W-1], hold.y} + (HIST_W + 1)'(1 << (OUT_FRAC - 1));
      rnd_hi  = rnd_sum[HIST_W:OUT_FRAC];
      if (rnd_hi[SAMPLE_W] != rnd_hi[SAMPLE_W-1]) begin
         sat_sample = rnd_hi[SAMPLE_W] ? {1'b1, {(SAMPLE_W - 1){1'b0}}}
                                       : {1'b0, {(SAMPLE_W - 1){1'b1}}};
      end else begin
         sat_sample = rnd_hi[SAMPLE_W-1:0];
      end
   end

   // Output register loads when it is empty or being emptied.
   assign take = hold.vld && (!out_vld_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (take) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) out_sample_ff <= sat_sample;
   end

   assign rsp_chan.valid      = out_vld_ff;
   assign rsp_chan.out_sample = out_sample_ff;

endmodule

/* rtl/core/iirdf1_chk.sv */
module iirdf1_chk (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [iirdf1_pkg::SAMPLE_W-1:0] rsp_sample
);
   import iirdf1_pkg::*;

   // Reset leaves the block empty and ready for a new sample.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

   // One sample is in work at a time.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while a sample is in work");

   // A result never appears right after a new sample is taken.
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared right after input acceptance");

   // A stalled result stays offered.
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its value.
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sample))
      else $error("result changed while stalled");

endmodule

bind iir_direct_form1_order8_top iirdf1_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_sample (rsp_chan.out_sample)
);
